@@ hw/rtl/hrhe_pkg.sv @@
package hrhe_pkg;

  localparam int NKEYS = 5;
  localparam int NEXTS = 7;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_DOT = 8'h2E;

  // Result kinds
  localparam logic [1:0] KIND_VALUE   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Field ids
  localparam logic [2:0] FIELD_HOST    = 3'd0;
  localparam logic [2:0] FIELD_REFERER = 3'd1;
  localparam logic [2:0] FIELD_GET     = 3'd2;
  localparam logic [2:0] FIELD_POST    = 3'd3;
  localparam logic [2:0] FIELD_AGENT   = 3'd4;
  localparam logic [2:0] FIELD_NONE    = 3'd7;

  // Request types
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_GET  = 2'd1;
  localparam logic [1:0] REQ_POST = 2'd2;

  localparam logic [9:0]  COUNT_MAX = 10'd1023;
  localparam logic [11:0] POS_MAX   = 12'd4095;

  // Keyword text, right-justified: last character in the low byte
  localparam logic [95:0] KW_TEXT [NKEYS] = '{
    "Host: ", "Referer: ", "GET ", "POST ", "User-Agent: "
  };
  localparam logic [3:0] KW_LEN [NKEYS] = '{4'd6, 4'd9, 4'd4, 4'd5, 4'd12};

  localparam logic [31:0] EXT_TEXT [NEXTS] = '{
    ".png", ".gif", ".jpg", ".bmp", ".css", ".js", ".swf"
  };
  localparam logic [2:0] EXT_LEN [NEXTS] = '{
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd4
  };

  typedef logic [NEXTS-1:0][2:0] ext_prog_t;

  typedef struct packed {
    ext_prog_t        prog;
    logic [NEXTS-1:0] seen;
  } ext_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] field;
    logic [7:0] value;
    logic [9:0] count;
    logic [1:0] rtype;
    logic       page;
    logic       last;
  } res_t;

  // True when byte b matches keyword k at line position pos
  function automatic logic kw_match(input logic [2:0] k, input logic [11:0] pos,
                                    input logic [7:0] b);
    logic [3:0] idx;
    idx = 4'(KW_LEN[k] - 4'd1 - pos[3:0]);
    if (pos >= {8'd0, KW_LEN[k]}) begin
      return 1'b0;
    end
    return KW_TEXT[k][{idx, 3'b000} +: 8] == b;
  endfunction

  // Advance every extension matcher by one byte
  function automatic ext_state_t ext_feed(input ext_state_t s, input logic [7:0] b);
    ext_state_t r;
    logic [2:0] p;
    logic [1:0] idx;
    r = s;
    for (int e = 0; e < NEXTS; e++) begin
      p = s.prog[e];
      idx = 2'(EXT_LEN[e] - 3'd1 - p);
      if (p < EXT_LEN[e] && EXT_TEXT[e][{idx, 3'b000} +: 8] == b) begin
        p = 3'(p + 3'd1);
      end else begin
        p = (b == CHAR_DOT) ? 3'd1 : 3'd0;
      end
      if (p >= EXT_LEN[e]) begin
        r.seen[e] = 1'b1;
        p = 3'd0;
      end
      r.prog[e] = p;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/http_request_header_extractor.sv @@
// HTTP request header extractor. Feed the request one byte per transaction on
// s_tdata, with s_tlast on the last byte of the packet. The block splits the
// bytes into CR LF lines, tags lines that start with "Host: ", "Referer: ",
// "GET ", "POST " or "User-Agent: ", and streams their value bytes out as they
// arrive (kind 0), at most VALUE_MAX-1 per line; value bytes are tentative, and
// a line-accepted result (kind 1) follows only when the tagged line ends in
// CR LF. A line with no CR LF within cfg line_limit bytes stops parsing until
// packet end. Every packet closes with one summary result (kind 2) holding the
// accepted-line count, the request type and a page-open flag (a GET path free
// of image, style, script and flash extensions). Each accepted input byte
// yields up to two results, which enter a four-entry result queue at the
// accepting edge and are offered on m_tvalid from the next cycle. The input
// side accepts a byte whenever the queue has room for two more. A byte that
// yields two results always follows a held CR, so the next byte yields at most
// one; with m_tready high the queue never holds more than two results and the
// block sustains one byte per cycle. Only output back-pressure fills the queue,
// and then the output drain rate of one result per cycle sets the pace.
// Write line_limit only while idle.
module http_request_header_extractor #(
  parameter int VALUE_MAX = 256
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: line_limit
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data,
  // input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_packet
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] field_id, [10:3] value_byte,
                                 // [20:11] header_count, [22:21] request_type,
                                 // [23] page_open
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast    // last result caused by this input byte
);

  localparam int CAP_W = $clog2(VALUE_MAX);
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(VALUE_MAX - 1);

  // parser state
  logic [11:0]                    line_limit;
  logic [11:0]                    line_position, line_position_next;
  logic [hrhe_pkg::NKEYS-1:0]     keyword_candidates, keyword_candidates_next;
  logic [2:0]                     current_field, current_field_next;
  logic [CAP_W-1:0]               captured_length, captured_length_next;
  logic                           pending_cr, pending_cr_next;
  logic                           parse_stopped, parse_stopped_next;
  logic [9:0]                     match_count, match_count_next;
  logic [1:0]                     request_kind, request_kind_next;
  hrhe_pkg::ext_state_t           ext, ext_next;
  logic                           path_has_ext, path_has_ext_next;

  // result queue
  hrhe_pkg::res_t fifo [4];
  logic [1:0]     head, tail;
  logic [2:0]     cnt;

  hrhe_pkg::res_t res [2];
  logic [1:0]     n_res;
  logic           in_fire, out_fire;

  assign cfg_ready = 1'b1;
  assign s_tready  = (cnt < 3'd3);
  assign in_fire   = s_tvalid & s_tready;
  assign m_tvalid  = (cnt != 3'd0);
  assign out_fire  = m_tvalid & m_tready;

  assign m_tuser = fifo[head].kind;
  assign m_tlast = fifo[head].last;
  assign m_tdata = {fifo[head].page, fifo[head].rtype, fifo[head].count,
                    fifo[head].value, fifo[head].field};

  always_comb begin
    logic [7:0]                 b;
    logic [7:0]                 sb;
    logic                       sen;
    logic [hrhe_pkg::NKEYS-1:0] keep;
    logic                       path;

    b    = s_tdata;
    sb   = 8'd0;
    sen  = 1'b0;
    keep = '0;
    path = (current_field == hrhe_pkg::FIELD_GET) || (current_field == hrhe_pkg::FIELD_POST);

    line_position_next      = line_position;
    keyword_candidates_next = keyword_candidates;
    current_field_next      = current_field;
    captured_length_next    = captured_length;
    pending_cr_next         = pending_cr;
    parse_stopped_next      = parse_stopped;
    match_count_next        = match_count;
    request_kind_next       = request_kind;
    ext_next                = ext;
    path_has_ext_next       = path_has_ext;

    res[0] = '0;
    res[1] = '0;
    n_res  = 2'd0;

    if (!parse_stopped) begin
      if (pending_cr && b == hrhe_pkg::CHAR_LF &&
          ({1'b0, line_position} + 13'd1) <= {1'b0, line_limit}) begin
        // line complete: confirm a tagged line, then start a fresh line
        if (current_field != hrhe_pkg::FIELD_NONE) begin
          if (match_count < hrhe_pkg::COUNT_MAX) begin
            match_count_next = match_count + 10'd1;
          end
          if (path) begin
            request_kind_next = (current_field == hrhe_pkg::FIELD_GET) ?
                                hrhe_pkg::REQ_GET : hrhe_pkg::REQ_POST;
            path_has_ext_next = (ext.seen != '0);
          end
          res[0].kind  = hrhe_pkg::KIND_ACCEPT;
          res[0].field = current_field;
          n_res        = 2'd1;
        end
        line_position_next      = '0;
        keyword_candidates_next = '1;
        current_field_next      = hrhe_pkg::FIELD_NONE;
        captured_length_next    = '0;
        pending_cr_next         = 1'b0;
        ext_next                = '0;
      end else begin
        if (current_field == hrhe_pkg::FIELD_NONE) begin
          // keyword search at this position
          for (int k = 0; k < hrhe_pkg::NKEYS; k++) begin
            if (keyword_candidates[k] && hrhe_pkg::kw_match(3'(k), line_position, b)) begin
              if (({8'd0, hrhe_pkg::KW_LEN[k]}) == line_position + 12'd1) begin
                current_field_next = 3'(k);
              end else begin
                keep[k] = 1'b1;
              end
            end
          end
          keyword_candidates_next = (current_field_next == hrhe_pkg::FIELD_NONE) ? keep : '0;
        end else if (!s_tlast) begin
          // value bytes: a held CR first, then this byte unless it is a CR
          for (int i = 0; i < 2; i++) begin
            sb  = (i == 0) ? hrhe_pkg::CHAR_CR : b;
            sen = (i == 0) ? pending_cr : (b != hrhe_pkg::CHAR_CR);
            if (sen && captured_length_next < CAP_MAX) begin
              captured_length_next = captured_length_next + CAP_W'(1);
              if (path) begin
                ext_next = hrhe_pkg::ext_feed(ext_next, sb);
              end
              res[n_res[0]].kind  = hrhe_pkg::KIND_VALUE;
              res[n_res[0]].field = current_field;
              res[n_res[0]].value = sb;
              n_res               = n_res + 2'd1;
            end
          end
        end
        pending_cr_next = (b == hrhe_pkg::CHAR_CR);
        if (line_position < hrhe_pkg::POS_MAX) begin
          line_position_next = line_position + 12'd1;
        end
        if (line_position_next >= line_limit) begin
          parse_stopped_next = 1'b1;
        end
      end
    end

    if (s_tlast) begin
      // packet summary, then drop all packet state
      res[n_res[0]].kind  = hrhe_pkg::KIND_SUMMARY;
      res[n_res[0]].count = match_count_next;
      res[n_res[0]].rtype = request_kind_next;
      res[n_res[0]].page  = (request_kind_next == hrhe_pkg::REQ_GET) && !path_has_ext_next;
      n_res               = n_res + 2'd1;

      line_position_next      = '0;
      keyword_candidates_next = '1;
      current_field_next      = hrhe_pkg::FIELD_NONE;
      captured_length_next    = '0;
      pending_cr_next         = 1'b0;
      ext_next                = '0;
      parse_stopped_next      = 1'b0;
      match_count_next        = '0;
      request_kind_next       = hrhe_pkg::REQ_NONE;
      path_has_ext_next       = 1'b0;
    end

    if (n_res == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n_res == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  // parser state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit         <= 12'd1024;
      line_position      <= '0;
      keyword_candidates <= '1;
      current_field      <= hrhe_pkg::FIELD_NONE;
      captured_length    <= '0;
      pending_cr         <= 1'b0;
      parse_stopped      <= 1'b0;
      match_count        <= '0;
      request_kind       <= hrhe_pkg::REQ_NONE;
      ext                <= '0;
      path_has_ext       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_limit <= cfg_data;
      end
      if (in_fire) begin
        line_position      <= line_position_next;
        keyword_candidates <= keyword_candidates_next;
        current_field      <= current_field_next;
        captured_length    <= captured_length_next;
        pending_cr         <= pending_cr_next;
        parse_stopped      <= parse_stopped_next;
        match_count        <= match_count_next;
        request_kind       <= request_kind_next;
        ext                <= ext_next;
        path_has_ext       <= path_has_ext_next;
      end
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      if (out_fire) begin
        head <= head + 2'd1;
      end
      if (in_fire) begin
        tail <= tail + n_res;
      end
      cnt <= cnt + (in_fire ? {1'b0, n_res} : 3'd0) - {2'b00, out_fire};
    end
  end

  // result queue payload: push up to two results per accepted byte
  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      fifo[tail] <= res[0];
    end
    if (in_fire && n_res == 2'd2) begin
      fifo[tail + 2'd1] <= res[1];
    end
  end

endmodule
